// ===== rtl/ial_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed array list package
// Field widths, operation and status codes, and the types shared between the
// command front end and the list engine.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int TDATA_W  = 48;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BACK   = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_REMOVE,
        OP_READ,
        OP_WRITE,
        OP_FIND,
        OP_FRONT,
        OP_BACK,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  data;
        logic [POS_W-1:0]           position;
        logic                       found;
        logic [STATUS_W-1:0]        status;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REM_FIRST,
        ST_REM_SHIFT,
        ST_FIND,
        ST_RESP
    } state_t;

    function automatic op_t decode_mode(input logic [MODE_W-1:0] mode);
        op_t op;
        unique case (mode)
            MODE_APPEND: op = OP_APPEND;
            MODE_REMOVE: op = OP_REMOVE;
            MODE_READ:   op = OP_READ;
            MODE_WRITE:  op = OP_WRITE;
            MODE_FIND:   op = OP_FIND;
            MODE_FRONT:  op = OP_FRONT;
            MODE_BACK:   op = OP_BACK;
            default:     op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/indexed_array_list.sv =====
// ----------------------------------------------------------------------------
// Indexed array list
// Ordered list of signed 32-bit words with append, remove at index, read,
// write, find, front and back; one result word for every input word.
// ----------------------------------------------------------------------------
// Input words pass through a two-entry command queue into the list engine,
// which keeps the entries in a memory with one write port and a registered
// read port and finishes one command before it starts the next. Append,
// write, every error and a find on an empty list load their result into the
// output register when the engine takes them; read, front and back first read
// the memory; remove at index i reads entry i, then each later entry moves
// down one place a cycle through the memory ports; find compares entries from
// the front, one compare a cycle, until a hit or the last entry. The queue
// registers commands, and a result in the output register does not stop new
// input words from entering the queue until both of its entries are taken.
module indexed_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mode[2:0], index[8:3], value[40:9], zero fill [47:41]
    input  logic [ial_pkg::TDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // data[31:0], position[37:32], found[38], status[40:39], count[47:41]
    output logic [ial_pkg::TDATA_W-1:0] m_tdata
);

    ial_pkg::cmd_t                  cmd;
    logic                           cmd_valid;
    logic                           cmd_ready;
    ial_pkg::res_t                  res;
    logic [ial_pkg::COUNT_W-1:0]    res_count;

    ial_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tdata[2:0]),
        .in_index  (s_tdata[8:3]),
        .in_value  (s_tdata[40:9]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ial_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_count (res_count)
    );

    assign m_tdata = {res_count, res.status, res.found, res.position, res.data};

endmodule

// ===== rtl/ial_front.sv =====
// ----------------------------------------------------------------------------
// Indexed array list command front end
// Accepts input words, decodes the mode into an operation and holds the
// commands in a two-entry queue in front of the list engine.
// ----------------------------------------------------------------------------
module ial_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ial_pkg::MODE_W-1:0]      in_mode,
    input  logic [ial_pkg::INDEX_W-1:0]     in_index,
    input  logic signed [ial_pkg::VALUE_W-1:0] in_value,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output ial_pkg::cmd_t                   cmd
);

    logic [1:0]     fill_reg, fill_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    ial_pkg::cmd_t  slot_reg [2];
    logic           push;
    logic           pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{op:    ial_pkg::decode_mode(in_mode),
                                      index: in_index,
                                      value: in_value};
        end
    end

endmodule

// ===== rtl/ial_back.sv =====
// ----------------------------------------------------------------------------
// Indexed array list engine
// Holds the element memory and the entry count, carries out one command at a
// time and places its result in the output register.
// ----------------------------------------------------------------------------
module ial_back #(
    parameter int CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  ial_pkg::cmd_t                   cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ial_pkg::res_t                   out_res,
    output logic [ial_pkg::COUNT_W-1:0]     out_count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ial_pkg::INDEX_W) ? CW : ial_pkg::INDEX_W;

    ial_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    ial_pkg::op_t       cur_op_reg, cur_op_next;
    logic signed [ial_pkg::VALUE_W-1:0] cur_value_reg, cur_value_next;
    ial_pkg::res_t      res_reg, res_next;

    logic                           out_valid_reg;
    ial_pkg::res_t                  out_res_reg, out_res_next;
    logic [ial_pkg::COUNT_W-1:0]    out_count_reg;
    logic                           out_load;
    logic                           out_free;

    logic signed [ial_pkg::VALUE_W-1:0] mem [CAPACITY];
    logic signed [ial_pkg::VALUE_W-1:0] rdata_reg;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [ial_pkg::VALUE_W-1:0] wr_data;

    logic           take;
    logic           idx_ok;
    logic           full;
    logic           empty;
    logic [CW:0]    ptr_p1;
    logic [CW:0]    ptr_p2;
    logic [CW:0]    cnt_w;
    logic           more1;
    logic           more2;
    logic           match;
    ial_pkg::res_t  res_ok;

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ial_pkg::ST_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;

    assign idx_ok = CMPW'(cmd.index) < CMPW'(count_reg);
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign ptr_p1 = (CW + 1)'(ptr_reg) + (CW + 1)'(1);
    assign ptr_p2 = (CW + 1)'(ptr_reg) + (CW + 1)'(2);
    assign cnt_w  = (CW + 1)'(count_reg);
    assign more1  = ptr_p1 < cnt_w;
    assign more2  = ptr_p2 < cnt_w;
    assign match  = (rdata_reg == cur_value_reg);
    assign res_ok = '{data: '0, position: '0, found: 1'b0, status: ial_pkg::STATUS_OK};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ial_pkg::ST_IDLE: begin
                if (take) begin
                    unique case (cmd.op) inside
                        ial_pkg::OP_REMOVE: begin
                            if (idx_ok) begin
                                state_next = ial_pkg::ST_REM_FIRST;
                            end
                        end
                        ial_pkg::OP_READ: begin
                            if (idx_ok) begin
                                state_next = ial_pkg::ST_READ;
                            end
                        end
                        ial_pkg::OP_FRONT, ial_pkg::OP_BACK: begin
                            if (!empty) begin
                                state_next = ial_pkg::ST_READ;
                            end
                        end
                        ial_pkg::OP_FIND: begin
                            if (!empty) begin
                                state_next = ial_pkg::ST_FIND;
                            end
                        end
                        default: state_next = ial_pkg::ST_IDLE;
                    endcase
                end
            end
            ial_pkg::ST_READ: state_next = ial_pkg::ST_RESP;
            ial_pkg::ST_REM_FIRST: begin
                state_next = more1 ? ial_pkg::ST_REM_SHIFT : ial_pkg::ST_RESP;
            end
            ial_pkg::ST_REM_SHIFT: begin
                if (!more2) begin
                    state_next = ial_pkg::ST_RESP;
                end
            end
            ial_pkg::ST_FIND: begin
                if (match || !more1) begin
                    state_next = ial_pkg::ST_RESP;
                end
            end
            ial_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = ial_pkg::ST_IDLE;
                end
            end
            default: state_next = ial_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = rdata_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cur_op_next    = cur_op_reg;
        cur_value_next = cur_value_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        out_res_next   = res_ok;
        unique case (state_reg)
            ial_pkg::ST_IDLE: begin
                if (take) begin
                    cur_op_next    = cmd.op;
                    cur_value_next = cmd.value;
                    res_next       = res_ok;
                    ptr_next       = AW'(cmd.index);
                    // Commands that finish here go straight to the output.
                    out_load       = 1'b1;
                    unique case (cmd.op) inside
                        ial_pkg::OP_APPEND: begin
                            if (full) begin
                                out_res_next.status = ial_pkg::STATUS_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = cmd.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ial_pkg::OP_WRITE: begin
                            if (idx_ok) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(cmd.index);
                                wr_data = cmd.value;
                            end else begin
                                out_res_next.status = ial_pkg::STATUS_RANGE;
                            end
                        end
                        ial_pkg::OP_REMOVE, ial_pkg::OP_READ: begin
                            if (idx_ok) begin
                                out_load = 1'b0;
                                rd_en    = 1'b1;
                                rd_addr  = AW'(cmd.index);
                            end else begin
                                out_res_next.status = ial_pkg::STATUS_RANGE;
                            end
                        end
                        ial_pkg::OP_FRONT, ial_pkg::OP_FIND: begin
                            if (!empty) begin
                                out_load = 1'b0;
                                rd_en    = 1'b1;
                                rd_addr  = '0;
                                ptr_next = '0;
                            end else if (cmd.op == ial_pkg::OP_FRONT) begin
                                out_res_next.status = ial_pkg::STATUS_RANGE;
                            end
                        end
                        ial_pkg::OP_BACK: begin
                            if (!empty) begin
                                out_load = 1'b0;
                                rd_en    = 1'b1;
                                rd_addr  = AW'(count_reg - CW'(1));
                            end else begin
                                out_res_next.status = ial_pkg::STATUS_RANGE;
                            end
                        end
                        default: begin
                            out_res_next.status = ial_pkg::STATUS_RANGE;
                        end
                    endcase
                end
            end
            ial_pkg::ST_READ: begin
                res_next.data = rdata_reg;
            end
            ial_pkg::ST_REM_FIRST: begin
                res_next.data = rdata_reg;
                if (more1) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(ptr_p1);
                end
            end
            ial_pkg::ST_REM_SHIFT: begin
                // Read data holds entry ptr+1; it moves down to ptr while the
                // next entry up is fetched.
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rdata_reg;
                ptr_next = AW'(ptr_p1);
                if (more2) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(ptr_p2);
                end
            end
            ial_pkg::ST_FIND: begin
                if (match) begin
                    res_next.found    = 1'b1;
                    res_next.position = ial_pkg::POS_W'(ptr_reg);
                end else if (more1) begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_p1);
                    ptr_next = AW'(ptr_p1);
                end
            end
            ial_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_res_next = res_reg;
                    if (cur_op_reg == ial_pkg::OP_REMOVE) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ial_pkg::ST_IDLE;
            count_reg     <= '0;
            cur_op_reg    <= ial_pkg::OP_APPEND;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cur_op_reg <= cur_op_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        cur_value_reg <= cur_value_next;
        res_reg       <= res_next;
        if (out_load) begin
            out_res_reg   <= out_res_next;
            out_count_reg <= ial_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_count = out_count_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ial_pkg::ST_REM_SHIFT) |-> (ptr_p1 < cnt_w))
        else $error("remove shift runs past the last entry");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ial_pkg::ST_RESP && out_free && cur_op_reg == ial_pkg::OP_REMOVE)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not drop the count by one");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_res_next.status == ial_pkg::STATUS_FULL) |-> full)
        else $error("full status reported on a list with room");

    a_found_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_res_next.found)
        |-> (state_reg == ial_pkg::ST_RESP && cur_op_reg == ial_pkg::OP_FIND))
        else $error("found flag set on a result that is not a find");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed array list testbench
// Drives command words into the list and checks every result word against a
// behavioral copy of the list that the testbench keeps itself. A short
// directed run covers the empty list, the extreme words, every operation and
// the range errors. A long random run then steers the fill level between empty
// and full. Both sides idle at random, and once the result side holds off
// long enough for the input to stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIST_DEPTH      = 64;
    localparam int RANDOM_WORDS    = 1925;
    localparam int MAX_GAP         = 18;
    localparam int HOLD_OFF_AT     = 900;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 80;

    localparam logic [ial_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct {
        logic signed [ial_pkg::VALUE_W-1:0] data;
        logic [ial_pkg::POS_W-1:0]          position;
        logic                               found;
        logic [ial_pkg::STATUS_W-1:0]       status;
        logic [ial_pkg::COUNT_W-1:0]        count;
    } list_reply_t;

    class list_scoreboard;
        logic signed [ial_pkg::VALUE_W-1:0] entries [LIST_DEPTH];
        int                                 fill;
        int                                 peak_fill;
        list_reply_t                        pending_replies [$];
        int                                 errors;
        int                                 replies_checked;
        int                                 full_flags;
        int                                 range_flags;
        int                                 find_hits;

        // Applies one accepted command to the list copy and queues its result.
        function void note_command(logic [ial_pkg::MODE_W-1:0] mode,
                                   logic [ial_pkg::INDEX_W-1:0] index,
                                   logic signed [ial_pkg::VALUE_W-1:0] value);
            list_reply_t r;
            r.data     = '0;
            r.position = '0;
            r.found    = 1'b0;
            r.status   = ial_pkg::STATUS_OK;
            case (mode)
                ial_pkg::MODE_APPEND: begin
                    if (fill >= LIST_DEPTH) begin
                        r.status = ial_pkg::STATUS_FULL;
                    end else begin
                        entries[fill] = value;
                        fill++;
                    end
                end
                ial_pkg::MODE_REMOVE: begin
                    if (int'(index) >= fill) begin
                        r.status = ial_pkg::STATUS_RANGE;
                    end else begin
                        r.data = entries[index];
                        for (int i = int'(index); i + 1 < fill; i++) begin
                            entries[i] = entries[i + 1];
                        end
                        fill--;
                    end
                end
                ial_pkg::MODE_READ: begin
                    if (int'(index) >= fill) r.status = ial_pkg::STATUS_RANGE;
                    else r.data = entries[index];
                end
                ial_pkg::MODE_WRITE: begin
                    if (int'(index) >= fill) r.status = ial_pkg::STATUS_RANGE;
                    else entries[index] = value;
                end
                ial_pkg::MODE_FIND: begin
                    for (int i = 0; i < fill; i++) begin
                        if (entries[i] == value) begin
                            r.found    = 1'b1;
                            r.position = ial_pkg::POS_W'(i);
                            break;
                        end
                    end
                end
                ial_pkg::MODE_FRONT: begin
                    if (fill == 0) r.status = ial_pkg::STATUS_RANGE;
                    else r.data = entries[0];
                end
                ial_pkg::MODE_BACK: begin
                    if (fill == 0) r.status = ial_pkg::STATUS_RANGE;
                    else r.data = entries[fill - 1];
                end
                default: begin
                    r.status = ial_pkg::STATUS_RANGE;
                end
            endcase
            r.count = ial_pkg::COUNT_W'(fill);
            if (fill > peak_fill) peak_fill = fill;
            if (r.status == ial_pkg::STATUS_FULL) full_flags++;
            if (r.status == ial_pkg::STATUS_RANGE) range_flags++;
            if (r.found) find_hits++;
            pending_replies.insert(pending_replies.size(), r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_reply(logic [ial_pkg::TDATA_W-1:0] word);
            list_reply_t                        want;
            logic signed [ial_pkg::VALUE_W-1:0] data;
            logic [ial_pkg::POS_W-1:0]          position;
            logic                               found;
            logic [ial_pkg::STATUS_W-1:0]       status;
            logic [ial_pkg::COUNT_W-1:0]        count;
            data     = word[31:0];
            position = word[37:32];
            found    = word[38];
            status   = word[40:39];
            count    = word[47:41];
            replies_checked++;
            if (pending_replies.size() == 0) begin
                report($sformatf("result word %h arrived with nothing expected", word));
                return;
            end
            want = pending_replies.pop_front();
            if (data !== want.data)
                report($sformatf("data %h, expected %h", data, want.data));
            if (position !== want.position)
                report($sformatf("position %0d, expected %0d", position, want.position));
            if (found !== want.found)
                report($sformatf("found %b, expected %b", found, want.found));
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            if (count !== want.count)
                report($sformatf("count %0d, expected %0d", count, want.count));
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ial_pkg::TDATA_W-1:0]   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ial_pkg::TDATA_W-1:0]   m_tdata;

    list_scoreboard sb;
    int             target_fill;
    int             target_left;
    int             words_sent;
    int             replies_taken;
    bit             send_steady;
    bit             take_steady;

    indexed_array_list #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance of the word.
    task automatic send_word(logic [ial_pkg::MODE_W-1:0] mode,
                             logic [ial_pkg::INDEX_W-1:0] index,
                             logic signed [ial_pkg::VALUE_W-1:0] value);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = draw_gap(send_steady);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, value, index, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(mode, index, value);
        words_sent++;
        @(negedge aclk);
    endtask

    // Steers the fill level toward a target that changes now and then, so the
    // list spends time empty, full and in between.
    task automatic send_random_word();
        logic [ial_pkg::MODE_W-1:0]         mode;
        logic [ial_pkg::INDEX_W-1:0]        index;
        logic signed [ial_pkg::VALUE_W-1:0] value;
        int                                 pick;
        if (target_left == 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) target_fill = 0;
            else if (pick == 1) target_fill = LIST_DEPTH;
            else target_fill = $urandom_range(1, LIST_DEPTH - 1);
            target_left = $urandom_range(40, 150);
        end
        target_left--;
        value = $urandom;
        if (sb.fill > 0 && $urandom_range(0, 99) < 85)
            index = ial_pkg::INDEX_W'($urandom_range(0, sb.fill - 1));
        else
            index = ial_pkg::INDEX_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            mode = MODE_UNUSED;
        end else if (sb.fill < target_fill && pick < 60) begin
            mode = ial_pkg::MODE_APPEND;
        end else if (sb.fill > target_fill && pick < 55) begin
            mode  = ial_pkg::MODE_REMOVE;
            index = ial_pkg::INDEX_W'($urandom_range(0, sb.fill - 1));
        end else begin
            mode = ial_pkg::MODE_W'($urandom_range(0, 6));
        end
        // Reuse stored words so that find hits and duplicate entries are common.
        if (sb.fill > 0 &&
            $urandom_range(0, 99) < (mode == ial_pkg::MODE_FIND ? 70 : 20))
            value = sb.entries[$urandom_range(0, sb.fill - 1)];
        send_word(mode, index, value);
    endtask

    initial begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        sb          = new();
        target_fill = 0;
        target_left = 0;
        words_sent  = 0;
        send_steady = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Empty list: every access is an error and find misses.
        send_word(ial_pkg::MODE_FRONT, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_BACK, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_READ, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_REMOVE, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_WRITE, 6'd0, 32'sd5);
        send_word(ial_pkg::MODE_FIND, 6'd0, 32'sd0);
        send_word(MODE_UNUSED, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_APPEND, 6'd0, 32'h7fff_ffff);
        send_word(ial_pkg::MODE_APPEND, 6'd63, 32'h8000_0000);
        send_word(ial_pkg::MODE_APPEND, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_APPEND, 6'd0, 32'hffff_ffff);
        send_word(ial_pkg::MODE_READ, 6'd63, 32'sd0);
        send_word(ial_pkg::MODE_READ, 6'd1, 32'sd0);
        send_word(ial_pkg::MODE_FIND, 6'd0, 32'hffff_ffff);
        send_word(ial_pkg::MODE_FIND, 6'd0, 32'h8000_0000);
        send_word(ial_pkg::MODE_FIND, 6'd0, 32'sd12345);
        send_word(ial_pkg::MODE_WRITE, 6'd3, 32'h7fff_fffe);
        send_word(ial_pkg::MODE_BACK, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_FRONT, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_REMOVE, 6'd0, 32'sd0);
        send_word(ial_pkg::MODE_REMOVE, 6'd3, 32'sd0);
        send_word(ial_pkg::MODE_REMOVE, 6'd2, 32'sd0);
        send_word(ial_pkg::MODE_READ, 6'd0, 32'sd0);
        send_word(MODE_UNUSED, 6'd63, 32'hffff_ffff);

        repeat (RANDOM_WORDS) send_random_word();
        s_tvalid = 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d command words and checked %0d results; %0d full-list appends,",
                 words_sent, sb.replies_checked, sb.full_flags);
        $display("%0d range or empty errors, %0d find hits, peak fill %0d of %0d entries.",
                 sb.range_flags, sb.find_hits, sb.peak_fill, LIST_DEPTH);
        if (sb.errors == 0) begin
            $display("** indexed_array_list: PASSED **");
        end else begin
            $display("** indexed_array_list: FAILED **");
        end
        $finish;
    end

    initial begin
        int gap;
        m_tready      = 1'b0;
        replies_taken = 0;
        take_steady   = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
            gap = draw_gap(take_steady);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_reply(m_tdata);
            replies_taken++;
            @(negedge aclk);
            // One long hold-off lets the command queue fill and stall the input.
            if (replies_taken == HOLD_OFF_AT) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
        $display("** indexed_array_list: FAILED **");
        $finish;
    end

endmodule

// ===== indexed_array_list.f =====
rtl/ial_pkg.sv
rtl/ial_front.sv
rtl/ial_back.sv
rtl/indexed_array_list.sv
test/testbench.sv
